>>> design/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types and constants of the energy voice activity end-of-utterance
// detector: payload words, register indexes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQUARE_W   = 31;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned ENERGY_W   = 31;
  localparam int unsigned FRAMES_W   = 16;
  localparam int unsigned SIL_W      = 10;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam int unsigned MAX_FRAME_SAMPLES_DEF = 512;

  localparam logic [ENERGY_W-1:0] SILENCE_ENERGY_RST = ENERGY_W'(40000);
  localparam logic [SIL_W-1:0]    SILENCE_LIMIT_RST  = SIL_W'(75);
  localparam logic [SIL_W-1:0]    IGNORE_COUNT_RST   = SIL_W'(25);
  localparam logic [FRAMES_W-1:0] MAX_FRAMES_RST     = FRAMES_W'(500);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SILENCE_ENERGY = 2'd0,
    CFG_SILENCE_LIMIT  = 2'd1,
    CFG_IGNORE_COUNT   = 2'd2,
    CFG_MAX_FRAMES     = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    CAUSE_NONE       = 2'd0,
    CAUSE_SILENCE    = 2'd1,
    CAUSE_MAX_FRAMES = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_ACC    = 2'd1,
    ST_DIV    = 2'd2,
    ST_DECIDE = 2'd3
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    logic                       new_recording;
  } in_word_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] frame_energy;
    logic [FRAMES_W-1:0] frames_done;
    logic [SIL_W-1:0]    silent_run;
    logic                speech_seen;
    logic                stop;
    cause_e              stop_cause;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic acc;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic fend;
    logic div_last;
    logic out_full;
  } ctrl_sts_t;

endpackage

>>> design/evad_ctrl.sv
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: takes a word, accumulates its square, runs the divider at a
// frame end and hands the frame decision to the output register.
// ----------------------------------------------------------------------------
module evad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  evad_pkg::ctrl_sts_t sts_i,
  output evad_pkg::ctrl_cmd_t cmd_o
);

  evad_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      evad_pkg::ST_IDLE: begin
        if (in_valid_i && !sts_i.skip) state_d = evad_pkg::ST_ACC;
      end
      evad_pkg::ST_ACC: begin
        state_d = sts_i.fend ? evad_pkg::ST_DIV : evad_pkg::ST_IDLE;
      end
      evad_pkg::ST_DIV: begin
        if (sts_i.div_last) state_d = evad_pkg::ST_DECIDE;
      end
      evad_pkg::ST_DECIDE: begin
        if (!sts_i.out_full) state_d = evad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      evad_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      evad_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
      end
      evad_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      evad_pkg::ST_DECIDE: begin
        cmd_o.load = !sts_i.out_full;
      end
    endcase
  end

endmodule

>>> design/evad_dpath.sv
// ----------------------------------------------------------------------------
// evad_dpath
// Datapath: configuration registers, squarer, saturating accumulator,
// bit-serial restoring divider, frame decision and output register.
// ----------------------------------------------------------------------------
module evad_dpath #(
  parameter int unsigned MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [evad_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [evad_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  evad_pkg::in_word_t                    in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output evad_pkg::out_word_t                   out_word_o,
  input  evad_pkg::ctrl_cmd_t                   cmd_i,
  output evad_pkg::ctrl_sts_t                   sts_o
);

  localparam int unsigned CW    = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SW    = evad_pkg::SUM_W;
  localparam int unsigned DCNTW = $clog2(evad_pkg::SUM_W);
  localparam int unsigned FW    = evad_pkg::FRAMES_W;
  localparam int unsigned LW    = evad_pkg::SIL_W;

  // configuration
  logic [evad_pkg::ENERGY_W-1:0] energy_thr_q;
  logic [LW-1:0]                 sil_limit_q;
  logic [LW-1:0]                 ignore_q;
  logic [FW-1:0]                 max_frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_thr_q <= evad_pkg::SILENCE_ENERGY_RST;
      sil_limit_q  <= evad_pkg::SILENCE_LIMIT_RST;
      ignore_q     <= evad_pkg::IGNORE_COUNT_RST;
      max_frames_q <= evad_pkg::MAX_FRAMES_RST;
    end else if (cfg_we_i) begin
      unique case (evad_pkg::cfg_e'(cfg_addr_i))
        evad_pkg::CFG_SILENCE_ENERGY: energy_thr_q <= cfg_data_i;
        evad_pkg::CFG_SILENCE_LIMIT:  sil_limit_q  <= cfg_data_i[LW-1:0];
        evad_pkg::CFG_IGNORE_COUNT:   ignore_q     <= cfg_data_i[LW-1:0];
        evad_pkg::CFG_MAX_FRAMES:     max_frames_q <= cfg_data_i[FW-1:0];
      endcase
    end
  end

  // recording state
  logic [SW-1:0] sum_q, sum_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [FW-1:0] frame_q;
  logic [LW-1:0] sil_q;
  logic          speech_q;
  logic          stopped_q;

  // sample pipeline and divider
  logic [evad_pkg::SQUARE_W-1:0] prod_q;
  logic signed [2*evad_pkg::SAMPLE_W-1:0] square;
  logic          fend_q;
  logic [SW-1:0] quo_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] den_q;
  logic [DCNTW-1:0] dcnt_q;

  assign square = in_word_i.sample * in_word_i.sample;

  // saturating accumulate
  logic [SW:0] sum_ext;
  always_comb begin
    sum_ext = {1'b0, sum_q} + (SW + 1)'(prod_q);
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    if (cnt_q < CW'(MAX_FRAME_SAMPLES)) begin
      sum_d = sum_ext[SW] ? '1 : sum_ext[SW-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  // one quotient bit per cycle
  logic [CW:0]   rem_sh, rem_diff;
  logic          qbit;
  always_comb begin
    rem_sh   = {rem_q, quo_q[SW-1]};
    rem_diff = rem_sh - {1'b0, den_q};
    qbit     = !rem_diff[CW];
  end

  // frame decision
  logic [FW-1:0] frame_d;
  logic [LW-1:0] sil_d;
  logic          speech_d, loud, stop_sil, stop_max;
  evad_pkg::cause_e cause;
  always_comb begin
    frame_d  = frame_q + 1'b1;
    loud     = quo_q > SW'(energy_thr_q);
    sil_d    = sil_q;
    speech_d = speech_q || loud;
    stop_sil = 1'b0;
    if (frame_d >= FW'(ignore_q)) begin
      priority if (loud) begin
        sil_d = '0;
      end else if (sil_q < sil_limit_q) begin
        sil_d = sil_q + 1'b1;
      end else begin
        sil_d = sil_limit_q;
      end
      stop_sil = speech_d && (sil_d >= sil_limit_q);
    end
    stop_max = !stop_sil && (frame_d >= max_frames_q);
    priority if (stop_sil) begin
      cause = evad_pkg::CAUSE_SILENCE;
    end else if (stop_max) begin
      cause = evad_pkg::CAUSE_MAX_FRAMES;
    end else begin
      cause = evad_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      cnt_q     <= '0;
      frame_q   <= '0;
      sil_q     <= '0;
      speech_q  <= 1'b0;
      stopped_q <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      if (cmd_i.accept && in_word_i.new_recording) begin
        sum_q     <= '0;
        cnt_q     <= '0;
        frame_q   <= '0;
        sil_q     <= '0;
        speech_q  <= 1'b0;
        stopped_q <= 1'b0;
      end
      if (cmd_i.acc) begin
        if (fend_q) begin
          sum_q  <= '0;
          cnt_q  <= '0;
          dcnt_q <= '0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
        end
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.load) begin
        frame_q   <= frame_d;
        sil_q     <= sil_d;
        speech_q  <= speech_d;
        stopped_q <= stopped_q || stop_sil || stop_max;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      prod_q <= square[evad_pkg::SQUARE_W-1:0];
      fend_q <= in_word_i.frame_end;
    end
    if (cmd_i.acc && fend_q) begin
      quo_q <= sum_d;
      den_q <= cnt_d;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SW-2:0], qbit};
      rem_q <= qbit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
    end
  end

  // output register
  logic out_valid_q, out_valid_d;
  evad_pkg::out_word_t out_word_q;

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_word_q.frame_energy <= quo_q[evad_pkg::ENERGY_W-1:0];
      out_word_q.frames_done  <= frame_d;
      out_word_q.silent_run   <= sil_d;
      out_word_q.speech_seen  <= speech_d;
      out_word_q.stop         <= stop_sil || stop_max;
      out_word_q.stop_cause   <= cause;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign sts_o.skip     = stopped_q && !in_word_i.new_recording;
  assign sts_o.fend     = fend_q;
  assign sts_o.div_last = dcnt_q == DCNTW'(SW - 1);
  assign sts_o.out_full = out_valid_q && !out_ready_i;

endmodule

>>> design/energy_vad_end_of_utterance.sv
// ----------------------------------------------------------------------------
// energy_vad_end_of_utterance
// Energy based end-of-utterance detector over framed 16-bit PCM samples.
// ----------------------------------------------------------------------------
// a sample word is taken and squared, then accumulated
// a frame-end word is taken and squared, accumulated, divided by the bit-serial
// divider and passed to the frame decision, which loads the output register
// the frame decision waits while an earlier result is stalled at the output
// a stopped recording takes and drops words until new_recording is set
// reset is asynchronous: config registers take their defaults, recording active
module energy_vad_end_of_utterance #(
  parameter int unsigned MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [evad_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  evad_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output evad_pkg::out_word_t             out_word_o
);

  evad_pkg::ctrl_cmd_t cmd;
  evad_pkg::ctrl_sts_t sts;

  evad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  evad_dpath #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> design/evad_checker.sv
// ----------------------------------------------------------------------------
// evad_checker
// Port level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module evad_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input evad_pkg::out_word_t             out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_stop_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.stop == (out_word_o.stop_cause != evad_pkg::CAUSE_NONE)))
    else $error("stop flag and stop cause disagree");

  a_silence_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stop_cause == evad_pkg::CAUSE_SILENCE
      |-> out_word_o.speech_seen)
    else $error("silence stop without speech");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while input side was idle");

endmodule

bind energy_vad_end_of_utterance evad_checker u_evad_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the energy end-of-utterance detector. A short
// table of directed words covers field extremes, stop causes and the corner
// settings of the registers, then random recordings run under several
// register settings. Every frame result is compared against pinned values
// or an in-bench model of the frame energy, silence run and stop
// decision, with random idle and stall cycles on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned       MAX_SAMPLES  = evad_pkg::MAX_FRAME_SAMPLES_DEF;
  localparam int unsigned       DATA_W       = evad_pkg::CFG_DATA_W;
  localparam longint unsigned   SUM_TOP      = (64'd1 << evad_pkg::SUM_W) - 64'd1;
  localparam int unsigned       SETTLE       = 50;
  localparam int unsigned       PHASES       = 8;
  localparam int unsigned       PHASE_ITEMS  = 216;
  localparam longint unsigned   LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic                 is_cfg;
    evad_pkg::cfg_e       cfg_sel;
    logic [DATA_W-1:0]    cfg_val;
    evad_pkg::in_word_t   word;
    logic                 pinned;
    evad_pkg::out_word_t  want;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [evad_pkg::CFG_ADDR_W-1:0] cfg_addr_i;
  logic [DATA_W-1:0]               cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  evad_pkg::in_word_t              in_word_i;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  evad_pkg::out_word_t             out_word_o;

  // model state and register copies
  logic [evad_pkg::ENERGY_W-1:0] thr_energy;
  logic [evad_pkg::SIL_W-1:0]    sil_lim;
  logic [evad_pkg::SIL_W-1:0]    skip_frames;
  logic [evad_pkg::FRAMES_W-1:0] frame_cap;
  longint unsigned               acc;
  longint unsigned               nsamp;
  logic [evad_pkg::FRAMES_W-1:0] frm_cnt;
  logic [evad_pkg::SIL_W-1:0]    sil_run;
  bit                            talk_seen;
  bit                            rec_halted;

  evad_pkg::out_word_t pending_frames[$];
  stim_row_t           dir_tab[$];
  evad_pkg::out_word_t want;
  int unsigned fails;
  int unsigned words_sent;
  int unsigned live_cnt;
  int unsigned frames_checked;
  int unsigned stops_silence;
  int unsigned stops_cap;
  int unsigned calm_in;
  int unsigned calm_out;
  int unsigned hold_left;
  longint unsigned cycle_cnt = 0;

  energy_vad_end_of_utterance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void clear_rec();
    acc        = 0;
    nsamp      = 0;
    frm_cnt    = '0;
    sil_run    = '0;
    talk_seen  = 1'b0;
    rec_halted = 1'b0;
  endfunction

  // returns 1 when the word closes a frame of an active recording
  function automatic bit predict_frame(input evad_pkg::in_word_t w,
                                       output evad_pkg::out_word_t r);
    longint           sv;
    longint unsigned  sq;
    longint unsigned  mean;
    bit               loud;
    bit               ends;
    evad_pkg::cause_e why;
    r    = '0;
    ends = 1'b0;
    why  = evad_pkg::CAUSE_NONE;
    if (w.new_recording) clear_rec();
    if (rec_halted) return 1'b0;
    if (nsamp < MAX_SAMPLES) begin
      sv = longint'($signed(w.sample));
      sq = sv * sv;
      if (acc > SUM_TOP - sq) acc = SUM_TOP;
      else acc = acc + sq;
      nsamp++;
    end
    if (!w.frame_end) return 1'b0;
    mean    = (nsamp != 0) ? acc / nsamp : 0;
    acc     = 0;
    nsamp   = 0;
    frm_cnt = frm_cnt + 1'b1;
    loud    = mean > thr_energy;
    if (frm_cnt < skip_frames) begin
      if (loud) talk_seen = 1'b1;
    end else begin
      if (loud) begin
        talk_seen = 1'b1;
        sil_run   = '0;
      end else if (sil_run < sil_lim) begin
        sil_run = sil_run + 1'b1;
      end else begin
        sil_run = sil_lim;
      end
      if (talk_seen && sil_run >= sil_lim) begin
        ends = 1'b1;
        why  = evad_pkg::CAUSE_SILENCE;
      end
    end
    if (!ends && frm_cnt >= frame_cap) begin
      ends = 1'b1;
      why  = evad_pkg::CAUSE_MAX_FRAMES;
    end
    if (ends) rec_halted = 1'b1;
    r.frame_energy = mean[evad_pkg::ENERGY_W-1:0];
    r.frames_done  = frm_cnt;
    r.silent_run   = sil_run;
    r.speech_seen  = talk_seen;
    r.stop         = ends;
    r.stop_cause   = why;
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t cfg_row(evad_pkg::cfg_e sel, logic [DATA_W-1:0] val);
    stim_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic stim_row_t word_row(int s, bit fe, bit nr);
    stim_row_t r;
    r                    = '0;
    r.word.sample        = 16'(s);
    r.word.frame_end     = fe;
    r.word.new_recording = nr;
    return r;
  endfunction

  function automatic stim_row_t known_row(int s, bit fe, bit nr, int unsigned en,
                                          int unsigned fr, int unsigned sr, bit sp,
                                          bit st, evad_pkg::cause_e c);
    stim_row_t r;
    r                   = word_row(s, fe, nr);
    r.pinned            = 1'b1;
    r.want.frame_energy = en[evad_pkg::ENERGY_W-1:0];
    r.want.frames_done  = fr[evad_pkg::FRAMES_W-1:0];
    r.want.silent_run   = sr[evad_pkg::SIL_W-1:0];
    r.want.speech_seen  = sp;
    r.want.stop         = st;
    r.want.stop_cause   = c;
    return r;
  endfunction

  task automatic put_sample(input evad_pkg::in_word_t w, input bit pinned,
                            input evad_pkg::out_word_t pinned_res);
    int unsigned         gap;
    evad_pkg::out_word_t r;
    bit                  has;
    if (calm_in != 0) begin
      calm_in--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 59) == 0) calm_in = $urandom_range(20, 80);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (!rec_halted || w.new_recording) live_cnt++;
    has = predict_frame(w, r);
    if (pinned) pending_frames.push_back(pinned_res);
    else if (has) pending_frames.push_back(r);
  endtask

  task automatic wait_frames_settled();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input evad_pkg::cfg_e sel, input logic [DATA_W-1:0] val);
    unique case (sel)
      evad_pkg::CFG_SILENCE_ENERGY: thr_energy  = val[evad_pkg::ENERGY_W-1:0];
      evad_pkg::CFG_SILENCE_LIMIT:  sil_lim     = val[evad_pkg::SIL_W-1:0];
      evad_pkg::CFG_IGNORE_COUNT:   skip_frames = val[evad_pkg::SIL_W-1:0];
      evad_pkg::CFG_MAX_FRAMES:     frame_cap   = val[evad_pkg::FRAMES_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= sel;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (calm_out != 0) calm_out--;
      else if ($urandom_range(0, 2) == 0) hold_left = idle_len();
      else if ($urandom_range(0, 99) == 0) calm_out = $urandom_range(30, 120);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $error("result word with no frame pending");
        fails++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (out_word_o.frame_energy !== want.frame_energy) begin
          $error("frame_energy: expected %0d, got %0d", want.frame_energy,
                 out_word_o.frame_energy);
          fails++;
        end
        if (out_word_o.frames_done !== want.frames_done) begin
          $error("frames_done: expected %0d, got %0d", want.frames_done,
                 out_word_o.frames_done);
          fails++;
        end
        if (out_word_o.silent_run !== want.silent_run) begin
          $error("silent_run: expected %0d, got %0d", want.silent_run,
                 out_word_o.silent_run);
          fails++;
        end
        if (out_word_o.speech_seen !== want.speech_seen) begin
          $error("speech_seen: expected %0d, got %0d", want.speech_seen,
                 out_word_o.speech_seen);
          fails++;
        end
        if (out_word_o.stop !== want.stop) begin
          $error("stop: expected %0d, got %0d", want.stop, out_word_o.stop);
          fails++;
        end
        if (out_word_o.stop_cause !== want.stop_cause) begin
          $error("stop_cause: expected %0d, got %0d", want.stop_cause,
                 out_word_o.stop_cause);
          fails++;
        end
        if (want.stop_cause == evad_pkg::CAUSE_SILENCE) stops_silence++;
        if (want.stop_cause == evad_pkg::CAUSE_MAX_FRAMES) stops_cap++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    evad_pkg::in_word_t w;
    int unsigned        quota;
    int unsigned        flen;
    int unsigned        rec_frames;
    int unsigned        pick;
    bit                 fresh;
    bit                 loud;
    bit                 long_left;
    logic [DATA_W-1:0]  val;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = evad_pkg::CFG_SILENCE_ENERGY;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    thr_energy  = evad_pkg::SILENCE_ENERGY_RST;
    sil_lim     = evad_pkg::SILENCE_LIMIT_RST;
    skip_frames = evad_pkg::IGNORE_COUNT_RST;
    frame_cap   = evad_pkg::MAX_FRAMES_RST;
    clear_rec();

    dir_tab = {
      known_row(-32768, 1, 0, 1073741824, 1, 0, 1, 0, evad_pkg::CAUSE_NONE),
      word_row(32767, 0, 0),
      word_row(0, 1, 0),
      word_row(1, 0, 0),
      word_row(-1, 0, 0),
      word_row(21845, 0, 0),
      known_row(-2, 1, 1, 4, 1, 0, 0, 0, evad_pkg::CAUSE_NONE),
      cfg_row(evad_pkg::CFG_MAX_FRAMES, 0),
      known_row(3, 1, 0, 9, 2, 0, 0, 1, evad_pkg::CAUSE_MAX_FRAMES),
      word_row(-32768, 1, 0),
      word_row(-21846, 0, 0),
      cfg_row(evad_pkg::CFG_MAX_FRAMES, 65535),
      cfg_row(evad_pkg::CFG_IGNORE_COUNT, 0),
      cfg_row(evad_pkg::CFG_SILENCE_LIMIT, 0),
      known_row(7, 1, 1, 49, 1, 0, 0, 0, evad_pkg::CAUSE_NONE),
      known_row(-300, 1, 0, 90000, 2, 0, 1, 1, evad_pkg::CAUSE_SILENCE),
      cfg_row(evad_pkg::CFG_SILENCE_ENERGY, 0),
      cfg_row(evad_pkg::CFG_SILENCE_LIMIT, 1),
      cfg_row(evad_pkg::CFG_MAX_FRAMES, 2),
      known_row(1, 1, 1, 1, 1, 0, 1, 0, evad_pkg::CAUSE_NONE),
      known_row(0, 1, 0, 0, 2, 1, 1, 1, evad_pkg::CAUSE_SILENCE),
      cfg_row(evad_pkg::CFG_SILENCE_ENERGY, 31'h4000_0000),
      cfg_row(evad_pkg::CFG_IGNORE_COUNT, 1023),
      cfg_row(evad_pkg::CFG_SILENCE_LIMIT, 1023),
      cfg_row(evad_pkg::CFG_MAX_FRAMES, 1),
      word_row(-32768, 0, 1),
      known_row(-32768, 1, 0, 1073741824, 1, 0, 0, 1, evad_pkg::CAUSE_MAX_FRAMES),
      cfg_row(evad_pkg::CFG_MAX_FRAMES, 500),
      cfg_row(evad_pkg::CFG_SILENCE_ENERGY, 40000),
      cfg_row(evad_pkg::CFG_SILENCE_LIMIT, 2),
      cfg_row(evad_pkg::CFG_IGNORE_COUNT, 1),
      word_row(200, 0, 1),
      known_row(-200, 1, 0, 40000, 1, 1, 0, 0, evad_pkg::CAUSE_NONE),
      known_row(201, 1, 0, 40401, 2, 0, 1, 0, evad_pkg::CAUSE_NONE),
      word_row(0, 1, 0),
      word_row(0, 1, 0),
      word_row(5, 1, 0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_frames_settled();
        write_reg(dir_tab[i].cfg_sel, dir_tab[i].cfg_val);
      end else begin
        put_sample(dir_tab[i].word, dir_tab[i].pinned, dir_tab[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_frames_settled();
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = 31'h4000_0000;
        2, 3, 4: val = DATA_W'($urandom_range(0, 5000));
        default: val = DATA_W'($urandom_range(0, 400000000));
      endcase
      write_reg(evad_pkg::CFG_SILENCE_ENERGY, val);
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = DATA_W'(1023);
        default: val = DATA_W'($urandom_range(1, 6));
      endcase
      write_reg(evad_pkg::CFG_SILENCE_LIMIT, val);
      if ($urandom_range(0, 9) == 0) val = DATA_W'(1023);
      else val = DATA_W'($urandom_range(0, 5));
      write_reg(evad_pkg::CFG_IGNORE_COUNT, val);
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = DATA_W'(1);
        2:       val = DATA_W'(65535);
        default: val = DATA_W'($urandom_range(4, 40));
      endcase
      write_reg(evad_pkg::CFG_MAX_FRAMES, val);

      quota     = live_cnt + PHASE_ITEMS;
      long_left = (p == 1);
      while (live_cnt < quota) begin
        fresh      = 1'b1;
        rec_frames = $urandom_range(2, 40);
        for (int f = 0; f < rec_frames && (f == 0 || !rec_halted) && live_cnt < quota; f++)
        begin
          if (long_left) begin
            flen      = $urandom_range(MAX_SAMPLES + 2, MAX_SAMPLES + 20);
            long_left = 1'b0;
          end else if ($urandom_range(0, 29) == 0) begin
            flen = $urandom_range(7, 40);
          end else begin
            flen = $urandom_range(1, 6);
          end
          loud = ($urandom_range(0, 99) < 35);
          for (int k = 0; k < flen; k++) begin
            pick = $urandom_range(0, 19);
            if (!loud) w.sample = 16'($urandom_range(0, 16) - 8);
            else if (pick == 0) w.sample = 16'h8000;
            else if (pick == 1) w.sample = 16'h7fff;
            else w.sample = 16'($urandom);
            w.frame_end     = (k == flen - 1);
            w.new_recording = fresh;
            fresh           = 1'b0;
            // broken framing
            if ($urandom_range(0, 39) == 0) w = evad_pkg::in_word_t'(18'($urandom));
            put_sample(w, 1'b0, '0);
          end
          if ($urandom_range(0, 149) == 0) wait_frames_settled();
        end
        // words into a stopped recording
        if (rec_halted) begin
          repeat ($urandom_range(0, 3)) begin
            w               = evad_pkg::in_word_t'(18'($urandom));
            w.new_recording = 1'b0;
            put_sample(w, 1'b0, '0);
          end
        end
      end
    end

    wait_frames_settled();
    $display("%0d sample words sent, %0d frame results checked over %0d random settings",
             words_sent, frames_checked, PHASES);
    $display("recordings ended: %0d by silence after speech, %0d by frame limit",
             stops_silence, stops_cap);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
design/evad_pkg.sv
design/evad_ctrl.sv
design/evad_dpath.sv
design/energy_vad_end_of_utterance.sv
design/evad_checker.sv
dv/tb_top.sv
